// ----- rtl/mlsched_pkg.sv -----
// package for the multilevel srtf / round-robin scheduler
// holds the task record type shared by the top level and the task memory
// no dependencies
`default_nettype none

package mlsched_pkg;

    localparam int unsigned TIME_W = 16;
    localparam logic [TIME_W-1:0] TIME_MAX = 16'hFFFF;

    localparam logic LEVEL_SRTF = 1'b0;
    localparam logic LEVEL_RR   = 1'b1;

    typedef struct packed {
        logic [TIME_W-1:0] arrival;
        logic [TIME_W-1:0] burst;
        logic [TIME_W-1:0] remaining;
        logic              level;
    } task_rec_t;

endpackage

`default_nettype wire

// ----- rtl/multilevel_srtf_rr_scheduler_core.sv -----
// top level of the two-level task scheduler (srtf level over round-robin level)
// depends on mlsched_pkg and mlsched_task_mem
`default_nettype none

// usage
//   command channel: a word is taken at a clock edge with start high and busy low
//   req_type 0 loads a slot (arrival, burst, level); req_type 1 is one time tick
//   a load leaves busy low, so loads can follow back to back
//   a tick holds busy through the slot scan, the execute step and, when a task
//   finishes, the two statistics steps; the finished word shows up on done_slot,
//   completion_time, turnaround and waiting with done high for one cycle, in the
//   same cycle that busy falls
//   the busy time is set by the slot scan: one memory read per slot through the
//   single read port of the task memory, one compare step per read, then an
//   update step and two arithmetic steps for the finish statistics
//   the result side has no back-pressure: done is a one-cycle strobe and must be
//   caught when it is high
//   configuration: apb write to any address with paddr[2] low (0 to 3) sets rr_quantum (4 bits)
//   reset: all slots invalid, tick counter, rotation pointer and quantum count
//   zero, rr_quantum 2; the task memory itself is not cleared, unwritten slots
//   are never looked at because their valid bit is low
module multilevel_srtf_rr_scheduler_core #(
    parameter int NUM_SLOTS = 16
) (
    input  wire         clk,
    input  wire         rst_n,
    // command channel
    input  wire         start,
    output logic        busy,
    input  wire         req_type,
    input  wire [3:0]   slot,
    input  wire [15:0]  arrival,
    input  wire [15:0]  burst,
    input  wire         level,
    // result channel
    output logic        done,
    output logic [3:0]  done_slot,
    output logic [15:0] completion_time,
    output logic [15:0] turnaround,
    output logic [15:0] waiting,
    // configuration port
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire [2:0]   paddr,
    input  wire [31:0]  pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam logic [SW-1:0] LAST_SLOT = SW'(NUM_SLOTS - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_LAST,
        ST_EXEC,
        ST_FIN1,
        ST_FIN2
    } state_t;

    // ------------------------------------------------------------------
    // configuration register
    // ------------------------------------------------------------------
    logic [3:0] rr_quantum_reg;
    logic       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == 1'b0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rr_quantum_reg <= 4'd2;
        end
        else if (cfg_wr)
        begin
            rr_quantum_reg <= pwdata[3:0];
        end
    end

    always_comb
    begin
        prdata = 32'd0;
        if (paddr[2] == 1'b0)
        begin
            prdata = {28'd0, rr_quantum_reg};
        end
    end

    // zero quantum behaves as one
    logic [3:0] quantum_eff;
    assign quantum_eff = (rr_quantum_reg == 4'd0) ? 4'd1 : rr_quantum_reg;

    // ------------------------------------------------------------------
    // state
    // ------------------------------------------------------------------
    state_t                 state_reg;
    logic [NUM_SLOTS-1:0]   valid_reg;
    logic [15:0]            now_reg;
    logic [SW-1:0]          rot_reg;
    logic [3:0]             qused_reg;

    // scan bookkeeping
    logic [SW-1:0]          addr_reg;      // slot being read this cycle
    logic [SW-1:0]          cnt_reg;       // reads issued so far
    logic [SW-1:0]          rd_slot_reg;   // slot whose word is on the read port
    logic                   rd_vld_reg;

    // best candidates of both levels
    logic                   l0_found_reg;
    logic [SW-1:0]          l0_slot_reg;
    mlsched_pkg::task_rec_t l0_rec_reg;
    logic                   l1_found_reg;
    logic [SW-1:0]          l1_slot_reg;
    mlsched_pkg::task_rec_t l1_rec_reg;

    // task that finished, and the partial statistics
    logic [SW-1:0]          sel_slot_reg;
    logic [15:0]            sel_arrival_reg;
    logic [15:0]            sel_burst_reg;
    logic [15:0]            turn_reg;

    // registered result word
    logic                   done_reg;
    logic [3:0]             done_slot_reg;
    logic [15:0]            completion_reg;
    logic [15:0]            turnaround_reg;
    logic [15:0]            waiting_reg;

    assign busy            = (state_reg != ST_IDLE);
    assign done            = done_reg;
    assign done_slot       = done_slot_reg;
    assign completion_time = completion_reg;
    assign turnaround      = turnaround_reg;
    assign waiting         = waiting_reg;

    // ------------------------------------------------------------------
    // task memory
    // ------------------------------------------------------------------
    logic                   mem_we;
    logic [SW-1:0]          mem_waddr;
    mlsched_pkg::task_rec_t mem_wdata;
    mlsched_pkg::task_rec_t mem_rdata;

    mlsched_task_mem #(
        .NUM_SLOTS (NUM_SLOTS),
        .SW        (SW)
    ) u_task_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (addr_reg),
        .rdata (mem_rdata)
    );

    // ------------------------------------------------------------------
    // command decode
    // ------------------------------------------------------------------
    logic          accept;
    logic          load_wr;
    logic          tick_go;
    logic [SW-1:0] load_idx;

    assign accept   = start && !busy;
    assign load_idx = SW'(slot);
    // loads past the end of the table are dropped
    assign load_wr  = accept && (req_type == 1'b0) && (8'(slot) < 8'(NUM_SLOTS));
    assign tick_go  = accept && (req_type == 1'b1);

    // ------------------------------------------------------------------
    // scan compare step: one slot per cycle
    // ------------------------------------------------------------------
    logic elig;
    logic take0;
    logic take1;

    always_comb
    begin
        elig  = rd_vld_reg && valid_reg[rd_slot_reg] && (mem_rdata.arrival <= now_reg);
        take0 = elig && (mem_rdata.level == mlsched_pkg::LEVEL_SRTF) &&
                (!l0_found_reg ||
                 (mem_rdata.remaining < l0_rec_reg.remaining) ||
                 ((mem_rdata.remaining == l0_rec_reg.remaining) &&
                  (rd_slot_reg < l0_slot_reg)));
        take1 = elig && (mem_rdata.level == mlsched_pkg::LEVEL_RR) && !l1_found_reg;
    end

    // ------------------------------------------------------------------
    // execute step: pick the task and work out its update
    // ------------------------------------------------------------------
    logic                   run_any;
    logic                   run_rr;
    logic [SW-1:0]          run_slot;
    mlsched_pkg::task_rec_t run_rec;
    logic [15:0]            rem_dec;
    logic                   finish;
    logic [3:0]             qused_next;
    logic [SW-1:0]          slot_inc;

    always_comb
    begin
        run_any = l0_found_reg || l1_found_reg;
        run_rr  = !l0_found_reg && l1_found_reg;
        if (l0_found_reg)
        begin
            run_slot = l0_slot_reg;
            run_rec  = l0_rec_reg;
        end
        else
        begin
            run_slot = l1_slot_reg;
            run_rec  = l1_rec_reg;
        end
        rem_dec    = run_rec.remaining - 16'd1;
        finish     = run_any && (rem_dec == 16'd0);
        // a different rr task restarts its quantum count
        qused_next = ((run_slot != rot_reg) ? 4'd0 : qused_reg) + 4'd1;
        slot_inc   = (run_slot == LAST_SLOT) ? '0 : run_slot + 1'b1;
    end

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = load_idx;
        mem_wdata = '{arrival: arrival, burst: burst, remaining: burst, level: level};
        if (load_wr)
        begin
            mem_we = 1'b1;
        end
        else if ((state_reg == ST_EXEC) && run_any)
        begin
            mem_we              = 1'b1;
            mem_waddr           = run_slot;
            mem_wdata           = run_rec;
            mem_wdata.remaining = rem_dec;
        end
    end

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            valid_reg       <= '0;
            now_reg         <= 16'd0;
            rot_reg         <= '0;
            qused_reg       <= 4'd0;
            addr_reg        <= '0;
            cnt_reg         <= '0;
            rd_slot_reg     <= '0;
            rd_vld_reg      <= 1'b0;
            l0_found_reg    <= 1'b0;
            l0_slot_reg     <= '0;
            l0_rec_reg      <= '0;
            l1_found_reg    <= 1'b0;
            l1_slot_reg     <= '0;
            l1_rec_reg      <= '0;
            sel_slot_reg    <= '0;
            sel_arrival_reg <= 16'd0;
            sel_burst_reg   <= 16'd0;
            turn_reg        <= 16'd0;
            done_reg        <= 1'b0;
            done_slot_reg   <= 4'd0;
            completion_reg  <= 16'd0;
            turnaround_reg  <= 16'd0;
            waiting_reg     <= 16'd0;
        end
        else
        begin
            done_reg <= 1'b0;

            // candidate update while scan words arrive
            if (take0)
            begin
                l0_found_reg <= 1'b1;
                l0_slot_reg  <= rd_slot_reg;
                l0_rec_reg   <= mem_rdata;
            end
            if (take1)
            begin
                l1_found_reg <= 1'b1;
                l1_slot_reg  <= rd_slot_reg;
                l1_rec_reg   <= mem_rdata;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    rd_vld_reg <= 1'b0;
                    if (load_wr)
                    begin
                        valid_reg[load_idx] <= (burst != 16'd0);
                    end
                    if (tick_go)
                    begin
                        // rr search order starts at the rotation pointer
                        addr_reg     <= rot_reg;
                        cnt_reg      <= '0;
                        l0_found_reg <= 1'b0;
                        l1_found_reg <= 1'b0;
                        state_reg    <= ST_SCAN;
                    end
                end

                ST_SCAN:
                begin
                    rd_slot_reg <= addr_reg;
                    rd_vld_reg  <= 1'b1;
                    addr_reg    <= (addr_reg == LAST_SLOT) ? '0 : addr_reg + 1'b1;
                    cnt_reg     <= cnt_reg + 1'b1;
                    if (cnt_reg == LAST_SLOT)
                    begin
                        state_reg <= ST_LAST;
                    end
                end

                ST_LAST:
                begin
                    // last word is compared this cycle
                    rd_vld_reg <= 1'b0;
                    state_reg  <= ST_EXEC;
                end

                ST_EXEC:
                begin
                    // saturating tick; equals the completion time of a finishing task
                    if (now_reg != mlsched_pkg::TIME_MAX)
                    begin
                        now_reg <= now_reg + 16'd1;
                    end
                    state_reg <= ST_IDLE;
                    if (run_any)
                    begin
                        if (run_rr)
                        begin
                            if (finish || (qused_next >= quantum_eff))
                            begin
                                rot_reg   <= slot_inc;
                                qused_reg <= 4'd0;
                            end
                            else
                            begin
                                rot_reg   <= run_slot;
                                qused_reg <= qused_next;
                            end
                        end
                        if (finish)
                        begin
                            valid_reg[run_slot] <= 1'b0;
                            sel_slot_reg        <= run_slot;
                            sel_arrival_reg     <= run_rec.arrival;
                            sel_burst_reg       <= run_rec.burst;
                            state_reg           <= ST_FIN1;
                        end
                    end
                end

                ST_FIN1:
                begin
                    turn_reg  <= now_reg - sel_arrival_reg;
                    state_reg <= ST_FIN2;
                end

                ST_FIN2:
                begin
                    done_reg       <= 1'b1;
                    done_slot_reg  <= 4'(sel_slot_reg);
                    completion_reg <= now_reg;
                    turnaround_reg <= turn_reg;
                    waiting_reg    <= (turn_reg > sel_burst_reg) ?
                                      (turn_reg - sel_burst_reg) : 16'd0;
                    state_reg      <= ST_IDLE;
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- rtl/mlsched_task_mem.sv -----
// task slot memory: one write port, one registered read port
// depends on mlsched_pkg for the task record type
`default_nettype none

module mlsched_task_mem #(
    parameter int NUM_SLOTS = 16,
    parameter int SW        = 4
) (
    input  wire                     clk,
    input  wire                     we,
    input  wire [SW-1:0]            waddr,
    input  mlsched_pkg::task_rec_t  wdata,
    input  wire [SW-1:0]            raddr,
    output mlsched_pkg::task_rec_t  rdata
);

    mlsched_pkg::task_rec_t mem [NUM_SLOTS];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire
